// File: sv/bwt_with_run_length_last_column_assert.svh
// Assertion macros for the BWT run-length block
`ifndef BWT_WITH_RUN_LENGTH_LAST_COLUMN_ASSERT_SVH
`define BWT_WITH_RUN_LENGTH_LAST_COLUMN_ASSERT_SVH

// same-cycle implication
`define BWTRL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define BWTRL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/bwtrl_pkg.sv
`timescale 1ns / 1ps
package bwtrl_pkg;
	localparam int BLOCK_LEN_DEF = 32;
	localparam int ROW_W = 5;
	localparam int RUN_W = 6;
	localparam int BYTE_W = 8;

	typedef struct packed {
		logic [BYTE_W-1:0] data_byte;
		logic              end_of_block;
	} in_item_t;

	typedef struct packed {
		logic              is_index;
		logic [ROW_W-1:0]  row_index;
		logic [RUN_W-1:0]  run_length;
		logic [BYTE_W-1:0] run_byte;
		logic              last_result;
		logic              overflow;
	} out_item_t;
endpackage

// File: sv/bwtrl_stream_if.sv
`timescale 1ns / 1ps
interface bwtrl_stream_if #(parameter type T = logic);
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: sv/bwt_with_run_length_last_column.sv
`timescale 1ns / 1ps
// channel  | dir | payload                                   | transaction
// item     | in  | data_byte, end_of_block                   | valid & ready
// result   | out | is_index, row_index, run_length,          | valid & ready
//          |     | run_byte, last_result, overflow           |
// Load: one byte per cycle. After end_of_block the rotations of n bytes are
// ranked by byte-serial compares through the single block RAM read port:
// per byte step the RA and RB states read both rotations and CMP compares;
// WR stores each rank. Readout reads order RAM (OA), block RAM (OB), emits (OC).
// Reset clears the byte count, overflow flag and output valid; RAM needs none.
// A stalled result holds the readout sequencer; input is taken only while loading.
`include "bwt_with_run_length_last_column_assert.svh"
module bwt_with_run_length_last_column
	import bwtrl_pkg::*;
#(
	parameter int BLOCK_LEN = BLOCK_LEN_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bwtrl_stream_if.sink   item,
	bwtrl_stream_if.source result
);
	localparam int AW = (BLOCK_LEN > 1) ? $clog2(BLOCK_LEN) : 1;
	localparam int LW = $clog2(BLOCK_LEN + 1);
	localparam int SW = LW + 1;

	typedef enum logic [9:0] {
		ST_LOAD = 10'b0000000001,
		ST_RA   = 10'b0000000010,
		ST_RB   = 10'b0000000100,
		ST_CMP  = 10'b0000001000,
		ST_WR   = 10'b0000010000,
		ST_IDX  = 10'b0000100000,
		ST_OA   = 10'b0001000000,
		ST_OB   = 10'b0010000000,
		ST_OC   = 10'b0100000000,
		ST_LAST = 10'b1000000000
	} state_t;

	state_t          state_q;
	logic [LW-1:0]   len_q;
	logic            ovf_q;
	logic [AW-1:0]   i_q, j_q, k_q, p_q, cnt_q, rank0_q;
	logic [LW-1:0]   eq0_q, run_q;
	logic [BYTE_W-1:0] x_q, cur_q;
	logic            res_valid_q;
	out_item_t       res_q;

	logic            acc, out_free, load_res, need_emit;
	out_item_t       res_d;
	logic [AW-1:0]   nm1, prev_addr;
	logic [SW-1:0]   sum_a, sum_b, row_sum;
	logic [AW-1:0]   addr_a, addr_b;
	logic            blk_we, blk_re, ord_re;
	logic [AW-1:0]   blk_raddr;
	logic [BYTE_W-1:0] blk_rdata;
	logic [AW-1:0]   ord_rdata;

	assign acc      = item.valid && item.ready;
	assign out_free = !res_valid_q || result.ready;
	assign nm1      = AW'(len_q - LW'(1));

	always_comb begin
		sum_a = SW'(i_q) + SW'(k_q);
		if (sum_a >= SW'(len_q)) begin
			sum_a = sum_a - SW'(len_q);
		end
		sum_b = SW'(j_q) + SW'(k_q);
		if (sum_b >= SW'(len_q)) begin
			sum_b = sum_b - SW'(len_q);
		end
	end
	assign addr_a    = AW'(sum_a);
	assign addr_b    = AW'(sum_b);
	assign prev_addr = (ord_rdata == '0) ? nm1 : ord_rdata - AW'(1);
	assign row_sum   = SW'(rank0_q) + SW'(eq0_q) - SW'(1);
	assign need_emit = (run_q != '0) && (blk_rdata != cur_q);

	assign blk_we = acc && (len_q < LW'(BLOCK_LEN));
	assign blk_re = (state_q == ST_RA) || (state_q == ST_RB) || (state_q == ST_OB);
	assign ord_re = (state_q == ST_OA);
	always_comb begin
		case (state_q)
			ST_RA:   blk_raddr = addr_a;
			ST_RB:   blk_raddr = addr_b;
			default: blk_raddr = prev_addr;
		endcase
	end

	bwtrl_ram #(.W(BYTE_W), .D(BLOCK_LEN)) u_blk (
		.clk(clk), .we(blk_we), .waddr(AW'(len_q)), .wdata(item.data.data_byte),
		.re(blk_re), .raddr(blk_raddr), .rdata_q(blk_rdata)
	);

	bwtrl_ram #(.W(AW), .D(BLOCK_LEN)) u_ord (
		.clk(clk), .we(state_q == ST_WR), .waddr(cnt_q), .wdata(i_q),
		.re(ord_re), .raddr(p_q), .rdata_q(ord_rdata)
	);

	always_comb begin
		load_res = 1'b0;
		res_d    = '0;
		res_d.overflow = ovf_q;
		case (state_q)
			ST_IDX: begin
				load_res        = out_free;
				res_d.is_index  = 1'b1;
				res_d.row_index = ROW_W'(row_sum);
			end
			ST_OC: begin
				load_res         = need_emit && out_free;
				res_d.run_length = RUN_W'(run_q);
				res_d.run_byte   = cur_q;
			end
			ST_LAST: begin
				load_res          = out_free;
				res_d.run_length  = RUN_W'(run_q);
				res_d.run_byte    = cur_q;
				res_d.last_result = 1'b1;
			end
			default: load_res = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			len_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
			i_q <= '0; j_q <= '0; k_q <= '0; p_q <= '0;
			cnt_q <= '0; rank0_q <= '0; eq0_q <= '0; run_q <= '0;
			x_q <= '0; cur_q <= '0;
		end else begin
			if (load_res) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			case (state_q)
				ST_LOAD: begin
					if (acc) begin
						if (len_q < LW'(BLOCK_LEN)) begin
							len_q <= len_q + LW'(1);
						end else begin
							ovf_q <= 1'b1;
						end
						if (item.data.end_of_block) begin
							i_q <= '0; j_q <= '0; k_q <= '0;
							cnt_q <= '0; eq0_q <= '0;
							state_q <= ST_RA;
						end
					end
				end
				ST_RA: state_q <= ST_RB;
				ST_RB: begin
					x_q     <= blk_rdata;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (x_q != blk_rdata || k_q == nm1) begin
						if (x_q != blk_rdata) begin
							if (blk_rdata < x_q) begin
								cnt_q <= cnt_q + AW'(1);
							end
						end else begin
							if (j_q < i_q) begin
								cnt_q <= cnt_q + AW'(1);
							end
							if (i_q == '0) begin
								eq0_q <= eq0_q + LW'(1);
							end
						end
						k_q <= '0;
						if (j_q == nm1) begin
							state_q <= ST_WR;
						end else begin
							j_q     <= j_q + AW'(1);
							state_q <= ST_RA;
						end
					end else begin
						k_q     <= k_q + AW'(1);
						state_q <= ST_RA;
					end
				end
				ST_WR: begin
					if (i_q == '0) begin
						rank0_q <= cnt_q;
					end
					cnt_q <= '0;
					j_q   <= '0;
					if (i_q == nm1) begin
						state_q <= ST_IDX;
					end else begin
						i_q     <= i_q + AW'(1);
						state_q <= ST_RA;
					end
				end
				ST_IDX: begin
					if (out_free) begin
						p_q     <= '0;
						run_q   <= '0;
						state_q <= ST_OA;
					end
				end
				ST_OA: state_q <= ST_OB;
				ST_OB: state_q <= ST_OC;
				ST_OC: begin
					if (!need_emit || out_free) begin
						run_q <= need_emit ? LW'(1) : run_q + LW'(1);
						cur_q <= blk_rdata;
						if (p_q == nm1) begin
							state_q <= ST_LAST;
						end else begin
							p_q     <= p_q + AW'(1);
							state_q <= ST_OA;
						end
					end
				end
				ST_LAST: begin
					if (out_free) begin
						len_q   <= '0;
						ovf_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				default: state_q <= ST_LOAD;
			endcase
		end
	end

	assign item.ready   = (state_q == ST_LOAD);
	assign result.valid = res_valid_q;
	assign result.data  = res_q;

	`BWTRL_ASSERT_NOW(a_len_cap, 1'b1, len_q <= LW'(BLOCK_LEN), "byte count above capacity")
	`BWTRL_ASSERT_NOW(a_idx_no_run, result.valid && result.data.is_index,
		result.data.run_length == '0 && !result.data.last_result, "index result carries run")
	`BWTRL_ASSERT_NEXT(a_clear_after_last, state_q == ST_LAST && out_free,
		len_q == '0 && !ovf_q && state_q == ST_LOAD, "block not cleared after final run")
	`BWTRL_ASSERT_NOW(a_sort_nonempty, state_q == ST_RA, len_q != '0, "sort on empty block")
endmodule

// File: sv/bwtrl_ram.sv
`timescale 1ns / 1ps
module bwtrl_ram #(
	parameter int W = 8,
	parameter int D = 32
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic                 re,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata_q
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end
endmodule

// File: dv/tb_bwt_with_run_length_last_column.sv
`timescale 1ns / 1ps
module tb_bwt_with_run_length_last_column;
	import bwtrl_pkg::*;

	localparam int N_MAX = BLOCK_LEN_DEF;
	localparam int WDOG_LIMIT = 400000;

	typedef struct {
		logic [7:0] b;
		logic       eob;
		bit         typed;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	always #2 clk = ~clk;

	bwtrl_stream_if #(.T(in_item_t))  item_if();
	bwtrl_stream_if #(.T(out_item_t)) res_if();

	bwt_with_run_length_last_column u_top (
		.clk(clk),
		.arst_n(arst_n),
		.item(item_if),
		.result(res_if)
	);

	// block model state
	logic [7:0] blk_bytes[N_MAX];
	int         blk_len;
	bit         blk_ovf;
	out_item_t  exp_results[$];

	bit  typed_now;
	bit  no_idle;
	int  errors;
	int  n_items;
	int  n_blocks;
	int  n_results;
	int  n_ovf_blocks;
	int  idle_cnt;

	function automatic int rot_order(int a, int c, int n);
		for (int k = 0; k < n; k++) begin
			if (blk_bytes[(a + k) % n] < blk_bytes[(c + k) % n])
				return -1;
			if (blk_bytes[(a + k) % n] > blk_bytes[(c + k) % n])
				return 1;
		end
		return 0;
	endfunction

	function automatic out_item_t mk_result(bit idx, int row, int len, logic [7:0] b,
			bit last, bit ovf);
		out_item_t r;
		r.is_index = idx;
		r.row_index = row[ROW_W-1:0];
		r.run_length = len[RUN_W-1:0];
		r.run_byte = b;
		r.last_result = last;
		r.overflow = ovf;
		return r;
	endfunction

	// accept one byte; on end mark compute index and last-column runs
	task automatic bwt_predict(in_item_t it);
		int order[N_MAX];
		int n, j, key, below, same, run;
		logic [7:0] cur, b;
		if (blk_len < N_MAX) begin
			blk_bytes[blk_len] = it.data_byte;
			blk_len++;
		end else
			blk_ovf = 1'b1;
		if (!it.end_of_block)
			return;
		n = blk_len;
		n_blocks++;
		if (blk_ovf)
			n_ovf_blocks++;
		if (!typed_now) begin
			for (int i = 0; i < n; i++) begin
				key = i;
				j = i;
				while (j > 0 && rot_order(order[j-1], key, n) > 0) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = key;
			end
			below = 0;
			same = 0;
			for (int i = 0; i < n; i++) begin
				if (rot_order(i, 0, n) < 0)
					below++;
				else if (rot_order(i, 0, n) == 0)
					same++;
			end
			exp_results.push_back(mk_result(1, below + same - 1, 0, 8'h00, 0, blk_ovf));
			run = 0;
			cur = 8'h00;
			for (int i = 0; i < n; i++) begin
				b = blk_bytes[(order[i] + n - 1) % n];
				if (run != 0 && b != cur) begin
					exp_results.push_back(mk_result(0, 0, run, cur, 0, blk_ovf));
					run = 0;
				end
				cur = b;
				run++;
			end
			exp_results.push_back(mk_result(0, 0, run, cur, 1, blk_ovf));
		end else begin
			// single byte block: row 0, one run of that byte
			exp_results.push_back(mk_result(1, 0, 0, 8'h00, 0, 0));
			exp_results.push_back(mk_result(0, 0, 1, it.data_byte, 1, 0));
		end
		blk_len = 0;
		blk_ovf = 1'b0;
	endtask

	function automatic void cmp_field(string name, int e, int a);
		if (e != a) begin
			$display("%0t ns: mismatch on %s: expected %0d, actual %0d", $time, name, e, a);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && item_if.valid && item_if.ready) begin
			n_items++;
			bwt_predict(item_if.data);
		end
		if (arst_n && res_if.valid && res_if.ready) begin
			n_results++;
			if (exp_results.size() == 0) begin
				$display("%0t ns: unexpected transaction on result, actual %p", $time,
					res_if.data);
				errors++;
			end else begin
				out_item_t e;
				e = exp_results.pop_front();
				cmp_field("is_index", e.is_index, res_if.data.is_index);
				cmp_field("row_index", e.row_index, res_if.data.row_index);
				cmp_field("run_length", e.run_length, res_if.data.run_length);
				cmp_field("run_byte", e.run_byte, res_if.data.run_byte);
				cmp_field("last_result", e.last_result, res_if.data.last_result);
				cmp_field("overflow", e.overflow, res_if.data.overflow);
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready))
			idle_cnt <= 0;
		else
			idle_cnt <= idle_cnt + 1;
		if (idle_cnt >= WDOG_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result back-pressure in bursts
	initial begin
		int gap;
		res_if.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			res_if.ready <= 1'b1;
			repeat ($urandom_range(1, 30)) @(negedge clk);
			if (!no_idle && $urandom_range(0, 2) != 0) begin
				gap = $urandom_range(1, 19);
				res_if.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end
		end
	end

	task automatic send(logic [7:0] b, logic eob, bit typed);
		@(negedge clk);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			item_if.valid <= 1'b0;
			repeat ($urandom_range(1, 19)) @(negedge clk);
		end
		typed_now = typed;
		item_if.valid <= 1'b1;
		item_if.data <= '{data_byte: b, end_of_block: eob};
		do @(posedge clk); while (!item_if.ready);
	endtask

	task automatic send_block(int len);
		for (int i = 0; i < len; i++)
			send(8'($urandom_range(0, 255)) & (($urandom_range(0, 1) != 0) ? 8'hff : 8'h03),
				i == len - 1, 0);
	endtask

	stim_row_t dir_rows[] = '{
		'{8'h00, 1'b1, 1'b1},
		'{8'hff, 1'b1, 1'b1},
		'{8'h80, 1'b1, 1'b1},
		'{8'h5a, 1'b0, 1'b0}, '{8'h5a, 1'b0, 1'b0}, '{8'h5a, 1'b1, 1'b0},
		'{8'h62, 1'b0, 1'b0}, '{8'h61, 1'b0, 1'b0}, '{8'h6e, 1'b0, 1'b0},
		'{8'h61, 1'b0, 1'b0}, '{8'h6e, 1'b0, 1'b0}, '{8'h61, 1'b1, 1'b0},
		'{8'h01, 1'b0, 1'b0}, '{8'hfe, 1'b0, 1'b0}, '{8'h01, 1'b0, 1'b0},
		'{8'hfe, 1'b1, 1'b0},
		'{8'hff, 1'b0, 1'b0}, '{8'h00, 1'b1, 1'b0},
		'{8'h00, 1'b0, 1'b0}, '{8'hff, 1'b0, 1'b0}, '{8'h7f, 1'b1, 1'b0}
	};

	initial begin
		int len;
		item_if.valid = 1'b0;
		item_if.data = '0;
		typed_now = 0;
		no_idle = 0;
		errors = 0;
		n_items = 0;
		n_blocks = 0;
		n_results = 0;
		n_ovf_blocks = 0;
		idle_cnt = 0;
		blk_len = 0;
		blk_ovf = 0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i])
			send(dir_rows[i].b, dir_rows[i].eob, dir_rows[i].typed);

		// full block, then an overflow block with end mark on a dropped byte
		send_block(N_MAX);
		send_block(N_MAX + 2);
		while (n_items < 110) begin
			if (n_items > 90)
				no_idle = 1;
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
			send_block(len);
		end
		@(negedge clk);
		item_if.valid <= 1'b0;

		while (exp_results.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		$display("Ran %0d input bytes in %0d blocks (%0d overflowed), %0d results checked.",
			n_items, n_blocks, n_ovf_blocks, n_results);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end
endmodule
